### rtl/core/lfsw_pkg.sv
// ---------------------------------------------------------------------------
// lfsw_pkg
// Shared types and constants for the LCD frame store link writer.
// ---------------------------------------------------------------------------
package lfsw_pkg;

   localparam int OP_W       = 3;
   localparam int SEEK_W     = 12;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 12;
   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 3;
   localparam int CSR_W      = 2;
   localparam int CSR_DATA_W = 6;
   localparam int CTR_W      = 6;
   localparam int OFFSET_W   = 3;

   localparam logic [BYTE_W-1:0]     CMD_PAGE      = 8'hB0;
   localparam logic [BYTE_W-1:0]     CMD_COL_HI    = 8'h10;
   localparam logic [BYTE_W-1:0]     CMD_CONTRAST  = 8'h81;
   localparam logic [BYTE_W-1:0]     NIBBLE_MASK   = 8'h0F;
   localparam logic [CTR_W-1:0]      CONTRAST_MASK = 6'h3F;
   localparam logic [CTR_W-1:0]      FLOOR_RESET   = 6'd30;
   localparam logic [CTR_W-1:0]      CEILING_RESET = 6'd40;
   localparam logic [OFFSET_W-1:0]   OFFSET_RESET  = 3'd4;
   localparam logic [MODE_W-1:0]     SEEK_ABSOLUTE = 2'd0;

   typedef enum logic [OP_W-1:0] {
      OP_SEEK         = 3'd0,
      OP_BEGIN_WRITE  = 3'd1,
      OP_WRITE_BYTE   = 3'd2,
      OP_BEGIN_READ   = 3'd3,
      OP_READ_BYTE    = 3'd4,
      OP_SET_CONTRAST = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK       = 3'd0,
      STS_TOO_LONG = 3'd1,
      STS_AT_END   = 3'd2,
      STS_PAST_END = 3'd3,
      STS_BAD_SEEK = 3'd4,
      STS_NO_RUN   = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      RUN_NONE  = 2'd0,
      RUN_WRITE = 2'd1,
      RUN_READ  = 2'd2
   } run_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_FLOOR   = 2'd0,
      CSR_CEILING = 2'd1,
      CSR_OFFSET  = 2'd2
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEEK,
      ST_SINGLE,
      ST_READ,
      ST_PAGE,
      ST_COL_HI,
      ST_COL_LO,
      ST_DATA,
      ST_CTR_CMD,
      ST_CTR_VAL
   } state_type;

   typedef struct packed {
      logic wr;
      logic rd;
   } store_cmd_type;

endpackage

### rtl/core/lcd_frame_store_link_writer.sv
// ---------------------------------------------------------------------------
// lcd_frame_store_link_writer
// Page-organized LCD frame store with cursor, run checks and link byte output.
// ---------------------------------------------------------------------------
// After reset the frame store is zero filled, one entry a cycle, across all
// PANEL_COLUMNS * PANEL_PAGES entries; req_stall stays high until that is done.
// The sequencer handles one request at a time: it accepts the request and
// then loads each of its results into the output register in turn. A seek
// failure, begin, plain write byte, read byte or unknown op gives one result,
// a write byte that carries page and column commands four, set contrast two.
// An accepted seek also walks the offset down one page a cycle and then loads
// the column before its result. A stalled result channel holds the sequencer
// until each result is loaded; the next request is taken while the final
// result still waits for transfer.
// ---------------------------------------------------------------------------
module lcd_frame_store_link_writer #(
   parameter int PANEL_COLUMNS = 128,
   parameter int PANEL_PAGES   = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [lfsw_pkg::OP_W-1:0]       req_op,
   input  logic [lfsw_pkg::SEEK_W-1:0]     req_seek_offset,
   input  logic [lfsw_pkg::MODE_W-1:0]     req_seek_mode,
   input  logic [lfsw_pkg::COUNT_W-1:0]    req_run_count,
   input  logic [lfsw_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic [lfsw_pkg::BYTE_W-1:0]     req_contrast_request,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_link_valid,
   output logic [lfsw_pkg::BYTE_W-1:0]     rsp_link_byte,
   output logic                            rsp_a0_flag,
   output logic [lfsw_pkg::BYTE_W-1:0]     rsp_read_value,
   output logic [lfsw_pkg::STATUS_W-1:0]   rsp_status,
   output logic [lfsw_pkg::BYTE_W-1:0]     rsp_contrast_report,
   output logic                            rsp_last,
   input  logic                            csr_write,
   input  logic [lfsw_pkg::CSR_W-1:0]      csr_index,
   input  logic [lfsw_pkg::CSR_DATA_W-1:0] csr_data
);
   import lfsw_pkg::*;

   localparam int STORE_SIZE = PANEL_COLUMNS * PANEL_PAGES;
   localparam int AW         = $clog2(STORE_SIZE);
   localparam int CUR_W      = $clog2(STORE_SIZE + 1);
   localparam int COL_W      = $clog2(PANEL_COLUMNS);
   localparam int PAGE_W     = $clog2(PANEL_PAGES + 1);
   localparam int SUM_W      = COUNT_W + 1;

   state_type             state_ff, state_in;
   logic [CUR_W-1:0]      cursor_ff, cursor_in;
   logic [CUR_W-1:0]      left_ff, left_in;
   run_type               kind_ff, kind_in;
   logic                  start_ff, start_in;
   logic [BYTE_W-1:0]     held_ff, held_in;
   logic [PAGE_W-1:0]     page_ff, page_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [CUR_W-1:0]      rem_ff, rem_in;
   status_type            status_ff, status_in;
   logic [BYTE_W-1:0]     data_ff, data_in;
   logic [CTR_W-1:0]      inv_ff, inv_in;
   logic [CTR_W-1:0]      floor_ff, ceiling_ff;
   logic [OFFSET_W-1:0]   offset_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_link_valid_ff;
   logic [BYTE_W-1:0]     rsp_link_byte_ff;
   logic                  rsp_a0_flag_ff;
   logic [BYTE_W-1:0]     rsp_read_value_ff;
   status_type            rsp_status_ff;
   logic [BYTE_W-1:0]     rsp_contrast_report_ff;
   logic                  rsp_last_ff;

   store_cmd_type         store_cmd;
   logic [BYTE_W-1:0]     store_rd_data;
   logic                  store_busy;

   logic                  accept;
   logic                  out_free;
   op_type                op;
   logic                  seek_ok;
   logic                  write_ok;
   logic                  read_ok;
   logic                  col_wrap;
   logic                  col_adv;
   status_type            begin_status;
   logic [BYTE_W-1:0]     clamp;
   logic [BYTE_W-1:0]     col_addr;

   logic                  emit;
   logic                  emit_link_valid;
   logic [BYTE_W-1:0]     emit_byte;
   logic                  emit_a0;
   logic [BYTE_W-1:0]     emit_read_value;
   logic                  emit_last;

   lfsw_store #(
      .DEPTH(STORE_SIZE)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .cmd     (store_cmd),
      .addr    (cursor_ff[AW-1:0]),
      .wr_data (req_data_byte),
      .rd_data (store_rd_data),
      .busy    (store_busy)
   );

   assign req_stall = (state_ff != ST_IDLE) || store_busy;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign op        = op_type'(req_op);

   assign seek_ok  = (req_seek_mode == SEEK_ABSOLUTE) &&
                     (SUM_W'(req_seek_offset) <= SUM_W'(STORE_SIZE));
   assign write_ok = (kind_ff == RUN_WRITE) && (left_ff != '0) &&
                     (cursor_ff < CUR_W'(STORE_SIZE));
   assign read_ok  = (kind_ff == RUN_READ) && (left_ff != '0) &&
                     (cursor_ff < CUR_W'(STORE_SIZE));
   assign col_wrap = ({1'b0, col_ff} + 1'b1) == (COL_W + 1)'(PANEL_COLUMNS);
   assign col_addr = BYTE_W'(col_ff) + BYTE_W'(offset_ff);

   always_comb begin
      if (SUM_W'(req_run_count) > SUM_W'(STORE_SIZE)) begin
         begin_status = STS_TOO_LONG;
      end else if (cursor_ff >= CUR_W'(STORE_SIZE)) begin
         begin_status = STS_AT_END;
      end else if (SUM_W'(cursor_ff) + SUM_W'(req_run_count) > SUM_W'(STORE_SIZE)) begin
         begin_status = STS_PAST_END;
      end else begin
         begin_status = STS_OK;
      end
   end

   always_comb begin
      clamp = req_contrast_request;
      if (clamp < BYTE_W'(floor_ff)) begin
         clamp = BYTE_W'(floor_ff);
      end
      if (clamp > BYTE_W'(ceiling_ff)) begin
         clamp = BYTE_W'(ceiling_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (op)
                  OP_SEEK:         state_in = seek_ok ? ST_SEEK : ST_SINGLE;
                  OP_WRITE_BYTE: begin
                     if (!write_ok) begin
                        state_in = ST_SINGLE;
                     end else if (start_ff || col_ff == '0) begin
                        state_in = ST_PAGE;
                     end else begin
                        state_in = ST_DATA;
                     end
                  end
                  OP_READ_BYTE:    state_in = read_ok ? ST_READ : ST_SINGLE;
                  OP_SET_CONTRAST: state_in = ST_CTR_CMD;
                  default:         state_in = ST_SINGLE;
               endcase
            end
         end
         ST_SEEK: begin
            if (rem_ff < CUR_W'(PANEL_COLUMNS)) begin
               state_in = ST_SINGLE;
            end
         end
         ST_PAGE:    if (out_free) state_in = ST_COL_HI;
         ST_COL_HI:  if (out_free) state_in = ST_COL_LO;
         ST_COL_LO:  if (out_free) state_in = ST_DATA;
         ST_CTR_CMD: if (out_free) state_in = ST_CTR_VAL;
         ST_SINGLE, ST_READ, ST_DATA, ST_CTR_VAL: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // result selection
   always_comb begin
      emit            = 1'b0;
      emit_link_valid = 1'b0;
      emit_byte       = '0;
      emit_a0         = 1'b0;
      emit_read_value = '0;
      emit_last       = 1'b0;
      case (state_ff)
         ST_SINGLE: begin
            emit      = out_free;
            emit_last = 1'b1;
         end
         ST_READ: begin
            emit            = out_free;
            emit_read_value = store_rd_data;
            emit_last       = 1'b1;
         end
         ST_PAGE: begin
            emit            = out_free;
            emit_link_valid = 1'b1;
            emit_byte       = CMD_PAGE | (BYTE_W'(page_ff) & NIBBLE_MASK);
         end
         ST_COL_HI: begin
            emit            = out_free;
            emit_link_valid = 1'b1;
            emit_byte       = CMD_COL_HI | (col_addr >> 4);
         end
         ST_COL_LO: begin
            emit            = out_free;
            emit_link_valid = 1'b1;
            emit_byte       = col_addr & NIBBLE_MASK;
         end
         ST_DATA: begin
            emit            = out_free;
            emit_link_valid = 1'b1;
            emit_byte       = data_ff;
            emit_a0         = 1'b1;
            emit_last       = 1'b1;
         end
         ST_CTR_CMD: begin
            emit            = out_free;
            emit_link_valid = 1'b1;
            emit_byte       = CMD_CONTRAST;
         end
         ST_CTR_VAL: begin
            emit            = out_free;
            emit_link_valid = 1'b1;
            emit_byte       = BYTE_W'(inv_ff);
            emit_last       = 1'b1;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // cursor, run and page tracking
   always_comb begin
      cursor_in = cursor_ff;
      left_in   = left_ff;
      kind_in   = kind_ff;
      start_in  = start_ff;
      held_in   = held_ff;
      page_in   = page_ff;
      col_in    = col_ff;
      rem_in    = rem_ff;
      status_in = status_ff;
      data_in   = data_ff;
      inv_in    = inv_ff;
      store_cmd = '{wr: 1'b0, rd: 1'b0};
      col_adv   = 1'b0;
      if (accept) begin
         status_in = STS_OK;
         case (op)
            OP_SEEK: begin
               if (seek_ok) begin
                  cursor_in = CUR_W'(req_seek_offset);
                  rem_in    = CUR_W'(req_seek_offset);
                  page_in   = '0;
                  kind_in   = RUN_NONE;
                  left_in   = '0;
               end else begin
                  status_in = STS_BAD_SEEK;
               end
            end
            OP_BEGIN_WRITE, OP_BEGIN_READ: begin
               status_in = begin_status;
               if (begin_status == STS_OK) begin
                  kind_in  = (op == OP_BEGIN_WRITE) ? RUN_WRITE : RUN_READ;
                  left_in  = CUR_W'(req_run_count);
                  start_in = 1'b1;
               end else begin
                  kind_in = RUN_NONE;
                  left_in = '0;
               end
            end
            OP_WRITE_BYTE: begin
               if (write_ok) begin
                  store_cmd.wr = 1'b1;
                  data_in      = req_data_byte;
                  cursor_in    = cursor_ff + 1'b1;
                  left_in      = left_ff - 1'b1;
                  start_in     = 1'b0;
               end else begin
                  status_in = STS_NO_RUN;
               end
            end
            OP_READ_BYTE: begin
               if (read_ok) begin
                  store_cmd.rd = 1'b1;
                  cursor_in    = cursor_ff + 1'b1;
                  left_in      = left_ff - 1'b1;
                  start_in     = 1'b0;
                  col_adv      = 1'b1;
               end else begin
                  status_in = STS_NO_RUN;
               end
            end
            OP_SET_CONTRAST: begin
               held_in = req_contrast_request;
               inv_in  = CONTRAST_MASK & ~clamp[CTR_W-1:0];
            end
            default: begin
               status_in = STS_OK;
            end
         endcase
      end
      if (state_ff == ST_SEEK) begin
         if (rem_ff >= CUR_W'(PANEL_COLUMNS)) begin
            rem_in  = rem_ff - CUR_W'(PANEL_COLUMNS);
            page_in = page_ff + 1'b1;
         end else begin
            col_in = rem_ff[COL_W-1:0];
         end
      end
      if (state_ff == ST_DATA && out_free) begin
         col_adv = 1'b1;
      end
      if (col_adv) begin
         if (col_wrap) begin
            col_in  = '0;
            page_in = page_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cursor_ff    <= '0;
         left_ff      <= '0;
         kind_ff      <= RUN_NONE;
         start_ff     <= 1'b1;
         held_ff      <= '0;
         page_ff      <= '0;
         col_ff       <= '0;
         floor_ff     <= FLOOR_RESET;
         ceiling_ff   <= CEILING_RESET;
         offset_ff    <= OFFSET_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         left_ff      <= left_in;
         kind_ff      <= kind_in;
         start_ff     <= start_in;
         held_ff      <= held_in;
         page_ff      <= page_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_type'(csr_index))
               CSR_FLOOR:   floor_ff   <= csr_data;
               CSR_CEILING: ceiling_ff <= csr_data;
               CSR_OFFSET:  offset_ff  <= csr_data[OFFSET_W-1:0];
               default:     offset_ff  <= offset_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      inv_ff    <= inv_in;
      if (emit) begin
         rsp_link_valid_ff      <= emit_link_valid;
         rsp_link_byte_ff       <= emit_byte;
         rsp_a0_flag_ff         <= emit_a0;
         rsp_read_value_ff      <= emit_read_value;
         rsp_status_ff          <= status_ff;
         rsp_contrast_report_ff <= held_ff;
         rsp_last_ff            <= emit_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_link_valid      = rsp_link_valid_ff;
   assign rsp_link_byte       = rsp_link_byte_ff;
   assign rsp_a0_flag         = rsp_a0_flag_ff;
   assign rsp_read_value      = rsp_read_value_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_contrast_report = rsp_contrast_report_ff;
   assign rsp_last            = rsp_last_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("accepted transfer did not start the sequencer");

   a_run_in_bounds: assert property (@(posedge clock) disable iff (reset)
      kind_ff != RUN_NONE |-> (SUM_W'(cursor_ff) + SUM_W'(left_ff)) <= SUM_W'(STORE_SIZE))
      else $error("open run reaches past the frame store");

   a_page_col_track: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |->
         (int'(page_ff) * PANEL_COLUMNS + int'(col_ff)) == int'(cursor_ff))
      else $error("page and column lost track of the cursor");

   a_no_access_while_clearing: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> !store_cmd.wr && !store_cmd.rd)
      else $error("frame store accessed during fill sweep");

endmodule

### rtl/core/lfsw_store.sv
// ---------------------------------------------------------------------------
// lfsw_store
// Frame store memory: one port, registered read, zero fill sweep after reset.
// ---------------------------------------------------------------------------
module lfsw_store #(
   parameter int DEPTH = 1024
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lfsw_pkg::store_cmd_type       cmd,
   input  logic [$clog2(DEPTH)-1:0]      addr,
   input  logic [lfsw_pkg::BYTE_W-1:0]   wr_data,
   output logic [lfsw_pkg::BYTE_W-1:0]   rd_data,
   output logic                          busy
);
   import lfsw_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;
   logic [AW-1:0]     clr_ff;
   logic [AW-1:0]     clr_in;
   logic              busy_ff;
   logic              busy_in;
   logic              we;
   logic [AW-1:0]     wa;
   logic [BYTE_W-1:0] wd;

   always_comb begin
      clr_in  = clr_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         clr_in = clr_ff + 1'b1;
         if (clr_ff == AW'(DEPTH - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff  <= '0;
         busy_ff <= 1'b1;
      end else begin
         clr_ff  <= clr_in;
         busy_ff <= busy_in;
      end
   end

   assign we = busy_ff || cmd.wr;
   assign wa = busy_ff ? clr_ff : addr;
   assign wd = busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (cmd.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = busy_ff;

endmodule
